// File: src/rcsr_pkg.sv
// Shared constants for the ring contour smoothstep remap unit.
// Register layout, register indexes and result width; no dependencies.
package rcsr_pkg;

  // Configuration registers are unsigned Q16 values
  localparam int unsigned REG_FRAC   = 16;
  localparam int unsigned CENTER_W   = 17;
  localparam int unsigned WIDTH_W    = 18;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_RING_CENTER = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_RING_WIDTH  = 1'b1;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 17'd32768;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 18'd32768;

  // Result level
  localparam int unsigned       LEVEL_W   = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

endpackage

// File: src/rcsr_if.sv
// Valid/ready stream interfaces for the coverage input and level output.
// Depends on rcsr_pkg for the level width.
interface rcsr_in_if #(
  parameter int unsigned COVERAGE_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [COVERAGE_BITS-1:0] coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

interface rcsr_out_if
  import rcsr_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] contour_level;

  modport source (output valid, output contour_level, input ready);
  modport sink   (input valid, input contour_level, output ready);
endinterface

// File: src/ring_contour_smoothstep_remap_unit.sv
// Ring contour smoothstep remap: top level and the whole datapath.
// Depends on rcsr_pkg and the stream interfaces in rcsr_if.sv.
//
// Usage: each beat on cov_i carries one coverage value; each beat on lvl_o
// carries the eased ring response for it, in order, one result per input.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The ring is set through cfg_we_i/cfg_idx_i/cfg_data_i: index 0 is the
// centre, index 1 the full width, both unsigned Q16. Write them only while
// no beat is in flight.
// Throughput: one beat per cycle while the skid slot is empty. Pipeline: the
// level register loads at the input beat's edge; then come the distance, the
// divider set-up, FRAC_BITS restoring divider steps (distance over the
// half-width, one quotient bit per stage), peak, square, ease, and output.
// Reset: centre and width return to 0.5, every stage and the output empty.
// Stall: the output register has a skid slot behind it. While the receiver
// holds ready low, the pipeline keeps moving and keeps taking beats until
// the skid slot fills; cov_i.ready then drops and the pipeline freezes, so
// no beat is lost or repeated. cov_i.ready is a register output and has no
// path from lvl_o.ready.
module ring_contour_smoothstep_remap_unit
  import rcsr_pkg::*;
#(
  parameter int unsigned COVERAGE_BITS = 8,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcsr_in_if.sink               cov_i,
  rcsr_out_if.source            lvl_o
);

  localparam int unsigned CB = COVERAGE_BITS;
  localparam int unsigned FB = FRAC_BITS;

  // Full-scale coverage
  localparam int unsigned CMAX      = (2 ** CB) - 1;
  localparam int unsigned HALF      = 2 ** (FB - 1);
  // Half-width floor of 0.05 in QF, rounded half up
  localparam int unsigned HMIN      = ((2 ** FB) + 10) / 20;

  // Copies of the coverage bits needed to cover F+1 fraction bits
  localparam int unsigned REP  = (FB + CB) / CB;
  localparam int unsigned REPW = REP * CB;

  localparam int unsigned QW  = FB + 2;       // level, centre, half-width, distance
  localparam int unsigned PW  = FB + 1;       // peak and its square
  localparam int unsigned FW  = FB + 2;       // 3 - 2*peak
  localparam int unsigned EW  = FB + 3;       // eased value
  localparam int unsigned SW  = EW + LEVEL_W; // eased value scaled to a level
  localparam int unsigned RW  = SW - FB;

  // Stages: level, distance, divider set-up, FB divider steps, peak,
  // square, ease
  localparam int unsigned NSTG   = FB + 6;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CENTER_W-1:0] center_q;
  logic [WIDTH_W-1:0]  width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RESET;
      width_q  <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RING_CENTER: center_q <= cfg_data_i[CENTER_W-1:0];
        REG_RING_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert the ring to QF once, off the item path. The user must change the
  // registers only while the pipeline is empty (unenforced), so the lag is harmless.
  logic [QW-1:0] center_qf_d, center_qf_q;
  logic [QW:0]   width_qf;
  logic [QW-1:0] half_w;
  logic [QW-1:0] half_d, half_q;

  if (FB >= REG_FRAC) begin : g_widen
    assign center_qf_d = QW'(center_q) << (FB - REG_FRAC);
    assign width_qf    = (QW + 1)'(width_q) << (FB - REG_FRAC);
  end else begin : g_narrow
    localparam int unsigned SH = REG_FRAC - FB;
    logic [CENTER_W:0] center_rnd;
    logic [WIDTH_W:0]  width_rnd;
    assign center_rnd  = {1'b0, center_q} + (CENTER_W + 1)'(2 ** (SH - 1));
    assign width_rnd   = {1'b0, width_q} + (WIDTH_W + 1)'(2 ** (SH - 1));
    assign center_qf_d = QW'(center_rnd >> SH);
    assign width_qf    = (QW + 1)'(width_rnd >> SH);
  end

  assign half_w = QW'(((QW + 2)'(width_qf) + (QW + 2)'(1)) >> 1);
  assign half_d = (half_w > QW'(HMIN)) ? half_w : QW'(HMIN);

  always_ff @(posedge clk_i) begin
    center_qf_q <= center_qf_d;
    half_q      <= half_d;
  end

  // ---------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid slot is full
  // ---------------------------------------------------------------------
  logic               en;
  logic [NSTG-1:0]    vld_q;
  logic               out_v_q, skid_v_q;
  logic [LEVEL_W-1:0] out_d_q, skid_d_q;
  logic [LEVEL_W-1:0] level_d;
  logic               push, pop;

  assign en          = !skid_v_q;
  assign cov_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], cov_i.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Level a = round(coverage * 2^F / CMAX). Below full scale coverage/CMAX
  // is the coverage bits repeated without end: take the first F bits of
  // the pattern and round on the bit after them. Full scale is 1.0.
  // ---------------------------------------------------------------------
  logic [REPW-1:0] cov_rep;
  logic [FB:0]     level_a_d;
  logic [FB:0]     level_a_q;

  assign cov_rep   = {REP{cov_i.coverage}};
  assign level_a_d = (cov_i.coverage == CB'(CMAX)) ? ((FB + 1)'(1) << FB)
                   : ((FB + 1)'(cov_rep[REPW-1 -: FB]) + (FB + 1)'(cov_rep[REPW-1-FB]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_a_q <= level_a_d;
    end
  end

  // ---------------------------------------------------------------------
  // Distance from the ring centre
  // ---------------------------------------------------------------------
  logic [QW-1:0] level_a;
  logic [QW-1:0] diff_q;

  assign level_a = QW'(level_a_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= (level_a >= center_qf_q) ? (level_a - center_qf_q)
                                         : (center_qf_q - level_a);
    end
  end

  // ---------------------------------------------------------------------
  // d = round(diff * 2^F / h). Anything at or beyond 1.0 only flags
  // overflow, since the peak is then zero; the quotient needs F bits.
  // ---------------------------------------------------------------------
  logic [QW-1:0] rb_q  [FB+1];
  logic [FB-1:0] lb_q  [FB+1];
  logic          ovf_q [FB+1];
  logic [QW-2:0] half_half;
  logic [QW-1:0] rb_init;
  logic          ovf_init;

  assign half_half = half_q[QW-1:1];
  assign rb_init   = diff_q + QW'(half_half[FB]);
  assign ovf_init  = rb_init >= half_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rb_q[0]  <= ovf_init ? '0 : rb_init;
      lb_q[0]  <= half_half[FB-1:0];
      ovf_q[0] <= ovf_init;
    end
  end

  for (genvar j = 1; j <= FB; j++) begin : g_div_b
    logic [QW:0] trial;
    logic        ge;
    assign trial = {rb_q[j-1], lb_q[j-1][FB-1]};
    assign ge    = trial >= {1'b0, half_q};
    always_ff @(posedge clk_i) begin
      if (en) begin
        rb_q[j]  <= ge ? QW'(trial - {1'b0, half_q}) : trial[QW-1:0];
        lb_q[j]  <= {lb_q[j-1][FB-2:0], ge};
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Peak, square, ease and scale
  // ---------------------------------------------------------------------
  logic [PW-1:0]      peak_q;
  logic [2*PW-1:0]    sq;
  logic [PW-1:0]      sq_q;
  logic [FW-1:0]      fac_q;
  logic [PW+FW-1:0]   ease_prod;
  logic [EW-1:0]      ease_q;
  logic [SW-1:0]      scaled;
  logic [RW-1:0]      rounded;

  always_ff @(posedge clk_i) begin
    if (en) begin
      peak_q <= ovf_q[FB] ? '0 : ((PW'(1) << FB) - PW'(lb_q[FB]));
    end
  end

  assign sq = (2 * PW)'(peak_q) * (2 * PW)'(peak_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q  <= PW'((sq + (2 * PW)'(HALF)) >> FB);
      fac_q <= (FW'(3) << FB) - (FW'(peak_q) << 1);
    end
  end

  assign ease_prod = (PW + FW)'(sq_q) * (PW + FW)'(fac_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ease_q <= EW'((ease_prod + (PW + FW)'(HALF)) >> FB);
    end
  end

  assign scaled  = SW'(ease_q) * SW'(LEVEL_MAX);
  assign rounded = RW'((scaled + SW'(HALF)) >> FB);
  assign level_d = (rounded > RW'(LEVEL_MAX)) ? LEVEL_MAX : rounded[LEVEL_W-1:0];

  // ---------------------------------------------------------------------
  // Output register with skid slot
  // ---------------------------------------------------------------------
  assign push = en && vld_q[NSTG-1];
  assign pop  = out_v_q && lvl_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      // pipeline frozen: drain the skid slot into the output
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= push;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_d_q <= skid_d_q;
      end
    end else if (!out_v_q || pop) begin
      out_d_q <= level_d;
    end else begin
      skid_d_q <= level_d;
    end
  end

  assign lvl_o.valid         = out_v_q;
  assign lvl_o.contour_level = out_d_q;

`ifndef NO_ASSERTIONS
  // The skid slot holds a beat only behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot full while output register empty");

  // The skid slot fills only when the output was held by the receiver
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !lvl_o.ready && vld_q[NSTG-1]))
    else $error("skid slot filled without a stalled output");

  // A full skid slot freezes every stage
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(vld_q))
    else $error("pipeline moved while skid slot full");

  // A fresh output beat comes from the last stage
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(vld_q[NSTG-1]))
    else $error("output beat appeared from an empty pipeline");
`endif

endmodule
